// ===== src/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared constants and types for the timer event queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = 4;
  localparam int IDX_W     = $clog2(SLOTS);

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_ARMED = 1'b1;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
    logic              status;
    logic              last;
  } result_t;

endpackage

// ===== src/tmq_out_stage.sv =====
// ----------------------------------------------------------------------------
// tmq_out_stage
// Output register for result items with valid/ready handshake.
// ----------------------------------------------------------------------------
module tmq_out_stage import tmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  result_t           push_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              fired,
  output logic [SLOT_W-1:0] fired_slot,
  output logic              status,
  output logic              last
);

  result_t held;

  assign free       = !out_valid || out_ready;
  assign fired      = held.fired;
  assign fired_slot = held.fired_slot;
  assign status     = held.status;
  assign last       = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

endmodule

// ===== src/timer_event_queue_with_wrap.sv =====
// ----------------------------------------------------------------------------
// timer_event_queue_with_wrap
// Arm and cancel: the result goes via the response state to the output register;
// the next input is taken back in idle. A tick runs a candidate pass, then per
// firing one minimum-deadline scan, a closing empty scan and a flush state; on
// wrap, old-bank slots first get firing and empty scans. Output stalls hold firing.
// One shared deadline comparator, one slot per cycle, serves both passes.
// Synchronous reset disarms all slots and clears the last tick time and bank.
// ----------------------------------------------------------------------------
module timer_event_queue_with_wrap import tmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [TIME_BITS-1:0] deadline,
  input  logic [TIME_BITS-1:0] period,
  input  logic [TIME_BITS-1:0] now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 fired,
  output logic [SLOT_W-1:0]    fired_slot,
  output logic                 status,
  output logic                 last
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BUILD  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FIRE   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]           state;
  logic [SLOTS-1:0]     armed;
  logic [SLOTS-1:0]     bank;
  logic [SLOTS-1:0]     cand;
  logic [TIME_BITS-1:0] dl [SLOTS];
  logic [TIME_BITS-1:0] per [SLOTS];
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] best_dl;
  logic                 current_bank;
  logic                 phase2;
  logic                 best_valid;
  logic                 pend_valid;
  logic                 resp_status;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     best;
  logic [IDX_W-1:0]     pend_slot;

  logic                 accept;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic                 idx_last;
  logic [TIME_BITS-1:0] cmp_a;
  logic [TIME_BITS-1:0] cmp_b;
  logic                 a_lt_b;
  logic                 a_eq_b;
  logic [TIME_BITS:0]   sum;
  logic                 fire_go;
  logic                 arm_we;
  logic                 rearm_we;
  logic                 push;
  logic                 out_free;
  result_t              push_data;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = (32'(slot) < SLOTS);
  assign slot_idx = slot[IDX_W-1:0];
  assign idx_last = (idx == IDX_W'(SLOTS - 1));

  // shared comparator: against now in the candidate pass, against best in the scan
  assign cmp_a  = dl[idx];
  assign cmp_b  = (state == S_BUILD) ? now_r : best_dl;
  assign a_lt_b = (cmp_a < cmp_b);
  assign a_eq_b = (cmp_a == cmp_b);

  // re-arm time, carry out marks a wrap
  assign sum = {1'b0, now_r} + {1'b0, per[best]};

  assign fire_go  = (state == S_FIRE) && best_valid && (!pend_valid || out_free);
  assign arm_we   = accept && (operation == OP_ARM) && slot_ok;
  assign rearm_we = fire_go && (per[best] != '0);

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    case (state)
      S_RESP: begin
        push             = out_free;
        push_data.status = resp_status;
        push_data.last   = 1'b1;
      end
      S_FIRE: begin
        push                 = fire_go && pend_valid;
        push_data.fired      = 1'b1;
        push_data.fired_slot = SLOT_W'(pend_slot);
      end
      S_FINISH: begin
        push                 = pend_valid && out_free;
        push_data.fired      = 1'b1;
        push_data.fired_slot = SLOT_W'(pend_slot);
        push_data.last       = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      armed        <= '0;
      cand         <= '0;
      last_time    <= '0;
      current_bank <= 1'b0;
      phase2       <= 1'b0;
      best_valid   <= 1'b0;
      pend_valid   <= 1'b0;
      idx          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (operation)
              OP_ARM: begin
                if (slot_ok) begin
                  armed[slot_idx] <= 1'b1;
                end
                state <= S_RESP;
              end
              OP_CANCEL: begin
                if (slot_ok) begin
                  armed[slot_idx] <= 1'b0;
                end
                state <= S_RESP;
              end
              OP_TICK: begin
                last_time  <= now;
                idx        <= '0;
                best_valid <= 1'b0;
                if (now < last_time) begin
                  // wrap: old bank slots fire first
                  current_bank <= ~current_bank;
                  cand         <= armed & ~(bank ^ {SLOTS{current_bank}});
                  phase2       <= 1'b0;
                  state        <= S_SCAN;
                end else begin
                  phase2 <= 1'b1;
                  state  <= S_BUILD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_BUILD: begin
          cand[idx] <= armed[idx] && (bank[idx] == current_bank) && (a_lt_b || a_eq_b);
          if (idx_last) begin
            idx   <= '0;
            state <= S_SCAN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          if (cand[idx] && (!best_valid || a_lt_b)) begin
            best_valid <= 1'b1;
          end
          if (idx_last) begin
            idx   <= '0;
            state <= S_FIRE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIRE: begin
          if (!best_valid) begin
            if (!phase2) begin
              phase2 <= 1'b1;
              state  <= S_BUILD;
            end else begin
              state <= S_FINISH;
            end
          end else if (fire_go) begin
            pend_valid <= 1'b1;
            cand[best] <= 1'b0;
            best_valid <= 1'b0;
            if (per[best] == '0) begin
              armed[best] <= 1'b0;
            end
            state <= S_SCAN;
          end
        end
        S_FINISH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // slot payload and datapath registers
  always_ff @(posedge clk) begin
    if (arm_we) begin
      dl[slot_idx]   <= deadline;
      per[slot_idx]  <= period;
      bank[slot_idx] <= current_bank;
    end else if (rearm_we) begin
      dl[best]   <= sum[TIME_BITS-1:0];
      bank[best] <= sum[TIME_BITS] ? ~current_bank : current_bank;
    end
    if (accept) begin
      now_r       <= now;
      resp_status <= (operation == OP_CANCEL && !(slot_ok && armed[slot_idx])) ?
                     STATUS_NOT_ARMED : STATUS_OK;
    end
    if (state == S_SCAN && cand[idx] && (!best_valid || a_lt_b)) begin
      best    <= idx;
      best_dl <= cmp_a;
    end
    if (fire_go) begin
      pend_slot <= best;
    end
  end

  tmq_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired      (fired),
    .fired_slot (fired_slot),
    .status     (status),
    .last       (last)
  );

  // a tick transfer always starts a multi-cycle pass
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_TICK |=> !in_ready)
    else $error("tick did not start a scan");

  // the held firing is always flushed before returning to idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending firing left at idle");

  // the chosen slot stays a candidate until it fires
  a_best_cand: assert property (@(posedge clk) disable iff (rst)
    best_valid |-> cand[best])
    else $error("selected slot is not a candidate");

  // firings never carry an error status
  a_fire_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == STATUS_OK)
    else $error("firing with error status");

  // a fired slot leaves the candidate set
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    fire_go |=> !cand[$past(best)])
    else $error("fired slot still a candidate");

endmodule
